// ===== hw/rtl/scancode_to_ascii_fifo_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scancode to ASCII FIFO
// Shared property templates; the asserting file supplies clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_FIFO_TOP_DEFINES_SVH
`define SCANCODE_TO_ASCII_FIFO_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SCF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define SCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/scfifo_pkg.sv =====
// ----------------------------------------------------------------------------
// scfifo_pkg
// Types, constants and key tables for the set 1 scancode decoder and key FIFO.
// ----------------------------------------------------------------------------
package scfifo_pkg;

  // Ring sizing; one entry is kept free to tell full from empty
  localparam int RING_DEPTH = 256;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  // Field widths
  localparam int KEY_W  = 9;
  localparam int SC_W   = 8;
  localparam int CHAR_W = 8;
  localparam int CFG_IDX_W = 1;

  // Input action codes
  localparam logic ACT_SCAN = 1'b0;
  localparam logic ACT_POLL = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_UP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_DOWN = 1'b1;

  // Scancodes of interest (7-bit make code)
  localparam logic [6:0] SC_LSHIFT = 7'h2A;
  localparam logic [6:0] SC_RSHIFT = 7'h36;
  localparam logic [6:0] SC_CAPS   = 7'h3A;
  localparam logic [6:0] SC_PGUP   = 7'h49;
  localparam logic [6:0] SC_PGDN   = 7'h51;
  localparam logic [6:0] TABLE_LEN = 7'd58;
  localparam logic [CHAR_W-1:0] CASE_STEP = 8'd32;

  localparam logic [KEY_W-1:0] PAGE_UP_RST   = 9'd256;
  localparam logic [KEY_W-1:0] PAGE_DOWN_RST = 9'd257;

  // Push request from the decoder to the ring
  typedef struct packed {
    logic             push;
    logic [KEY_W-1:0] code;
  } push_req_t;

  // Ring pointer increment with wrap
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(RING_DEPTH - 1)) r = '0;
    else                             r = p + 1'b1;
    return r;
  endfunction

  // Unshifted key table, entries 0..57
  function automatic logic [CHAR_W-1:0] plain_char(input logic [5:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      6'd1:  c = 8'h1B;  6'd2:  c = 8'h31;  6'd3:  c = 8'h32;  6'd4:  c = 8'h33;
      6'd5:  c = 8'h34;  6'd6:  c = 8'h35;  6'd7:  c = 8'h36;  6'd8:  c = 8'h37;
      6'd9:  c = 8'h38;  6'd10: c = 8'h39;  6'd11: c = 8'h30;  6'd12: c = 8'h2D;
      6'd13: c = 8'h3D;  6'd14: c = 8'h08;  6'd15: c = 8'h09;  6'd16: c = 8'h71;
      6'd17: c = 8'h77;  6'd18: c = 8'h65;  6'd19: c = 8'h72;  6'd20: c = 8'h74;
      6'd21: c = 8'h79;  6'd22: c = 8'h75;  6'd23: c = 8'h69;  6'd24: c = 8'h6F;
      6'd25: c = 8'h70;  6'd26: c = 8'h5B;  6'd27: c = 8'h5D;  6'd28: c = 8'h0A;
      6'd30: c = 8'h61;  6'd31: c = 8'h73;  6'd32: c = 8'h64;  6'd33: c = 8'h66;
      6'd34: c = 8'h67;  6'd35: c = 8'h68;  6'd36: c = 8'h6A;  6'd37: c = 8'h6B;
      6'd38: c = 8'h6C;  6'd39: c = 8'h3B;  6'd40: c = 8'h27;  6'd41: c = 8'h60;
      6'd43: c = 8'h5C;  6'd44: c = 8'h7A;  6'd45: c = 8'h78;  6'd46: c = 8'h63;
      6'd47: c = 8'h76;  6'd48: c = 8'h62;  6'd49: c = 8'h6E;  6'd50: c = 8'h6D;
      6'd51: c = 8'h2C;  6'd52: c = 8'h2E;  6'd53: c = 8'h2F;  6'd55: c = 8'h2A;
      6'd57: c = 8'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Shifted key table, entries 0..57
  function automatic logic [CHAR_W-1:0] upper_char(input logic [5:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      6'd1:  c = 8'h1B;  6'd2:  c = 8'h21;  6'd3:  c = 8'h40;  6'd4:  c = 8'h23;
      6'd5:  c = 8'h24;  6'd6:  c = 8'h25;  6'd7:  c = 8'h5E;  6'd8:  c = 8'h26;
      6'd9:  c = 8'h2A;  6'd10: c = 8'h28;  6'd11: c = 8'h29;  6'd12: c = 8'h5F;
      6'd13: c = 8'h2B;  6'd14: c = 8'h08;  6'd15: c = 8'h09;  6'd16: c = 8'h51;
      6'd17: c = 8'h57;  6'd18: c = 8'h45;  6'd19: c = 8'h52;  6'd20: c = 8'h54;
      6'd21: c = 8'h59;  6'd22: c = 8'h55;  6'd23: c = 8'h49;  6'd24: c = 8'h4F;
      6'd25: c = 8'h50;  6'd26: c = 8'h7B;  6'd27: c = 8'h7D;  6'd28: c = 8'h0A;
      6'd30: c = 8'h41;  6'd31: c = 8'h53;  6'd32: c = 8'h44;  6'd33: c = 8'h46;
      6'd34: c = 8'h47;  6'd35: c = 8'h48;  6'd36: c = 8'h4A;  6'd37: c = 8'h4B;
      6'd38: c = 8'h4C;  6'd39: c = 8'h3A;  6'd40: c = 8'h22;  6'd41: c = 8'h7E;
      6'd43: c = 8'h7C;  6'd44: c = 8'h5A;  6'd45: c = 8'h58;  6'd46: c = 8'h43;
      6'd47: c = 8'h56;  6'd48: c = 8'h42;  6'd49: c = 8'h4E;  6'd50: c = 8'h4D;
      6'd51: c = 8'h3C;  6'd52: c = 8'h3E;  6'd53: c = 8'h3F;  6'd55: c = 8'h2A;
      6'd57: c = 8'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/scfifo_decode.sv =====
// ----------------------------------------------------------------------------
// scfifo_decode
// Set 1 scancode decoder: modifier state, page key codes and table lookup.
// ----------------------------------------------------------------------------
module scfifo_decode (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                scan_en,
  input  logic [scfifo_pkg::SC_W-1:0]         scancode,
  input  logic                                cfg_write_en,
  input  logic [scfifo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scfifo_pkg::KEY_W-1:0]        cfg_data,
  output scfifo_pkg::push_req_t               push_req
);
  import scfifo_pkg::*;

  logic             shift_r, shift_nxt;
  logic             caps_r, caps_nxt;
  logic [KEY_W-1:0] page_up_r, page_down_r;
  logic             brk;
  logic [6:0]       low;
  logic             is_shift;
  logic [CHAR_W-1:0] ch;

  // Decode one scancode transfer
  always_comb begin
    brk       = scancode[SC_W-1];
    low       = scancode[6:0];
    is_shift  = (low == SC_LSHIFT) || (low == SC_RSHIFT);
    shift_nxt = shift_r;
    caps_nxt  = caps_r;
    push_req  = '0;
    ch        = shift_r ? upper_char(low[5:0]) : plain_char(low[5:0]);
    // caps flips letter case against shift
    if (caps_r && !shift_r && ch >= 8'h61 && ch <= 8'h7A) begin
      ch = ch - CASE_STEP;
    end else if (caps_r && shift_r && ch >= 8'h41 && ch <= 8'h5A) begin
      ch = ch + CASE_STEP;
    end
    if (scan_en) begin
      if (brk) begin
        if (is_shift) shift_nxt = 1'b0;
      end else if (is_shift) begin
        shift_nxt = 1'b1;
      end else if (low == SC_CAPS) begin
        caps_nxt = !caps_r;
      end else if (low == SC_PGUP) begin
        push_req.push = 1'b1;
        push_req.code = page_up_r;
      end else if (low == SC_PGDN) begin
        push_req.push = 1'b1;
        push_req.code = page_down_r;
      end else if (low < TABLE_LEN) begin
        push_req.push = (ch != '0);
        push_req.code = KEY_W'(ch);
      end
    end
  end

  // Modifier state and page key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= 1'b0;
      caps_r      <= 1'b0;
      page_up_r   <= PAGE_UP_RST;
      page_down_r <= PAGE_DOWN_RST;
    end else begin
      shift_r <= shift_nxt;
      caps_r  <= caps_nxt;
      if (cfg_write_en) begin
        unique case (cfg_index)
          CFG_PAGE_UP:   page_up_r   <= cfg_data;
          CFG_PAGE_DOWN: page_down_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/scfifo_ring.sv =====
// ----------------------------------------------------------------------------
// scfifo_ring
// Key code ring in a synchronous memory, pop stage and output register.
// ----------------------------------------------------------------------------
module scfifo_ring (
  input  logic                           clk,
  input  logic                           rst_n,
  input  scfifo_pkg::push_req_t          push_req,
  input  logic                           pop_en,
  input  logic                           out_stall,
  output logic                           stage_blocked,
  output logic                           out_valid,
  output logic [scfifo_pkg::KEY_W-1:0]   out_key_code,
  output logic                           out_empty_res
);
  import scfifo_pkg::*;

  logic [KEY_W-1:0] ring_mem [RING_DEPTH];
  logic [KEY_W-1:0] rd_data_r;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_inc;
  logic             ring_full, ring_empty, do_write, do_read;
  logic             s1_valid_r, s1_valid_nxt, s1_empty_r, s1_move;
  logic             out_valid_r, out_valid_nxt, out_empty_r;
  logic [KEY_W-1:0] out_key_r;

  // Pointer compare and stage movement
  always_comb begin
    wr_ptr_inc    = ptr_inc(wr_ptr_r);
    ring_full     = (wr_ptr_inc == rd_ptr_r);
    ring_empty    = (wr_ptr_r == rd_ptr_r);
    do_write      = push_req.push && !ring_full;
    do_read       = pop_en && !ring_empty;
    s1_move       = s1_valid_r && (!out_valid_r || !out_stall);
    stage_blocked = s1_valid_r && out_valid_r && out_stall;
    wr_ptr_nxt    = do_write ? wr_ptr_inc : wr_ptr_r;
    rd_ptr_nxt    = do_read ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    if (pop_en)       s1_valid_nxt = 1'b1;
    else if (s1_move) s1_valid_nxt = 1'b0;
    else              s1_valid_nxt = s1_valid_r;
    if (s1_move)                       out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    else                               out_valid_nxt = out_valid_r;
  end

  // Ring memory; a popped entry was always written at an earlier edge
  always_ff @(posedge clk) begin
    if (do_write) ring_mem[wr_ptr_r] <= push_req.code;
    if (do_read)  rd_data_r <= ring_mem[rd_ptr_r];
  end

  // Payload of the pop stage and output register
  always_ff @(posedge clk) begin
    if (pop_en) s1_empty_r <= ring_empty;
    if (s1_move) begin
      out_empty_r <= s1_empty_r;
      out_key_r   <= s1_empty_r ? '0 : rd_data_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_code  = out_key_r;
  assign out_empty_res = out_empty_r;

endmodule

// ===== hw/rtl/scancode_to_ascii_fifo_top.sv =====
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_top
// Set 1 scancode decoder feeding a key code ring with poll interface.
//
//   channel | direction | handshake        | payload
//   in      | input     | in_valid/stall   | in_action, in_scancode
//   out     | output    | out_valid/stall  | out_key_code, out_empty_res
//   cfg     | input     | cfg_write_en     | cfg_index, cfg_data
//
// One transfer per cycle on the input while in_stall is low; a scancode yields no result.
// A poll result is registered first in the pop stage by the ring memory read,
// then in the output register.
// Reset clears pointers and modifiers and loads the default page codes; the
// ring needs no clearing.
// in_stall rises only while both the pop stage and the output are held by
// out_stall.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_action,
  input  logic [scfifo_pkg::SC_W-1:0]        in_scancode,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [scfifo_pkg::KEY_W-1:0]       out_key_code,
  output logic                               out_empty_res,
  input  logic                               cfg_write_en,
  input  logic [scfifo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scfifo_pkg::KEY_W-1:0]       cfg_data
);
  import scfifo_pkg::*;

  logic      in_xfer, scan_en, pop_en, stage_blocked;
  push_req_t push_req;

  // Input transfer split by action
  assign in_stall = stage_blocked;
  assign in_xfer  = in_valid && !in_stall;
  assign scan_en  = in_xfer && (in_action == ACT_SCAN);
  assign pop_en   = in_xfer && (in_action == ACT_POLL);

  scfifo_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .scan_en      (scan_en),
    .scancode     (in_scancode),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push_req     (push_req)
  );

  scfifo_ring u_ring (
    .clk           (clk),
    .rst_n         (rst_n),
    .push_req      (push_req),
    .pop_en        (pop_en),
    .out_stall     (out_stall),
    .stage_blocked (stage_blocked),
    .out_valid     (out_valid),
    .out_key_code  (out_key_code),
    .out_empty_res (out_empty_res)
  );

endmodule

// ===== hw/rtl/scfifo_checker.sv =====
// ----------------------------------------------------------------------------
// scfifo_checker
// Port-level checks on the scancode to ASCII FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "scancode_to_ascii_fifo_top_defines.svh"

module scfifo_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_action,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [scfifo_pkg::KEY_W-1:0]      out_key_code,
  input logic                              out_empty_res
);
  import scfifo_pkg::*;

  // Held result stays put
  `SCF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_key_code) && $stable(out_empty_res), "stalled result changed")

  // Empty poll reports a zero code
  `SCF_ASSERT(a_empty_zero, out_valid && out_empty_res, out_key_code == '0, "empty poll with nonzero code")

  // A poll transfer shows a result after the pop stage and the output register
  `SCF_ASSERT_NEXT(a_poll_result, in_valid && !in_stall && (in_action == ACT_POLL), ##1 out_valid, "poll result missing")

  // Input backpressure only comes from a stalled output
  `SCF_ASSERT(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output stall")

endmodule

bind scancode_to_ascii_fifo_top scfifo_checker u_scfifo_checker (.*);
